// ===== rtl/tccg_pkg.sv =====
// ----------------------------------------------------------------------------
// tccg_pkg
// Shared types, codes and palette for the text cell glyph renderer.
// ----------------------------------------------------------------------------
package tccg_pkg;

	// default glyph height in rows
	localparam int GLYPH_ROWS_DEF = 16;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// request command codes
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// classified request kind carried through the queue
	typedef enum logic {
		KIND_DRAW = 1'b0,
		KIND_LOAD = 1'b1
	} entry_kind_t;

	// 16-entry ARGB palette: index bit 3 selects the bright half
	localparam logic [31:0] PALETTE [16] = '{
		32'hff000000, 32'hff0000aa, 32'hff00aa00, 32'hff0055aa,
		32'hffaa0000, 32'hffaa00aa, 32'hffaaaa00, 32'hffaaaaaa,
		32'hff555555, 32'hff5555ff, 32'hff55ff55, 32'hff55ffff,
		32'hffff5555, 32'hffff55ff, 32'hffffff55, 32'hffffffff
	};

	// one queued request, colors already resolved to ARGB
	typedef struct packed {
		entry_kind_t kind;
		logic [7:0]  code;
		logic [31:0] fg_argb;
		logic [31:0] bg_argb;
		logic [10:0] pix_x;
		logic [11:0] pix_y_base;
		logic [3:0]  font_row;
		logic [7:0]  font_bits;
	} entry_t;

endpackage

// ===== rtl/tccg_front.sv =====
// ----------------------------------------------------------------------------
// tccg_front
// Accepts requests, classifies them, resolves colors and positions, and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tccg_front import tccg_pkg::*; #(
	parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  char_code,
	input  logic [2:0]  fg_color,
	input  logic [2:0]  bg_color,
	input  logic        bold,
	input  logic        invert,
	input  logic [7:0]  cell_col,
	input  logic [7:0]  cell_row,
	input  logic [3:0]  font_row,
	input  logic [7:0]  font_bits,
	output logic        head_valid,
	output entry_t      head,
	input  logic        pop
);

	entry_t             queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	entry_t             entry;
	logic [31:0]        fg_sel;
	logic [31:0]        bg_sel;
	logic               accept;
	logic               push;

	// color resolve: bold picks bright foreground, invert swaps, code zero blanks
	always_comb begin
		fg_sel = PALETTE[{bold, fg_color}];
		bg_sel = PALETTE[{1'b0, bg_color}];
		entry            = '0;
		entry.kind       = (cmd == CMD_LOAD) ? KIND_LOAD : KIND_DRAW;
		entry.code       = char_code;
		entry.fg_argb    = invert ? bg_sel : fg_sel;
		entry.bg_argb    = invert ? fg_sel : bg_sel;
		if (char_code == 8'd0) begin
			entry.fg_argb = '0;
			entry.bg_argb = '0;
		end
		entry.pix_x      = {cell_col, 3'b000};
		entry.pix_y_base = 12'({4'b0000, cell_row} * 12'(GLYPH_ROWS));
		entry.font_row   = font_row;
		entry.font_bits  = font_bits;
	end

	// loads past the glyph height are accepted and dropped
	assign in_stall   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign accept     = in_valid && !in_stall;
	assign push       = accept && !(cmd == CMD_LOAD && 32'(font_row) >= GLYPH_ROWS);
	assign head_valid = (count_q != '0);
	assign head       = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/tccg_back.sv =====
// ----------------------------------------------------------------------------
// tccg_back
// Executes queued requests: font row writes, and per-cell row sequencing
// through the font memory into a registered pixel output.
// ----------------------------------------------------------------------------
module tccg_back import tccg_pkg::*; #(
	parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pixel_y,
	output logic [10:0] pixel_x,
	output logic [31:0] pixel_0,
	output logic [31:0] pixel_1,
	output logic [31:0] pixel_2,
	output logic [31:0] pixel_3,
	output logic [31:0] pixel_4,
	output logic [31:0] pixel_5,
	output logic [31:0] pixel_6,
	output logic [31:0] pixel_7,
	output logic        last
);

	localparam int ROW_W      = $clog2(GLYPH_ROWS);
	localparam int ADDR_W     = 8 + ROW_W;
	localparam int FONT_DEPTH = 1 << ADDR_W;

	logic [7:0]       font_mem [FONT_DEPTH];
	logic [ROW_W-1:0] row_q;
	logic             valid_s1;
	logic [7:0]       bits_s1;
	logic [31:0]      fg_s1;
	logic [31:0]      bg_s1;
	logic [11:0]      y_s1;
	logic [10:0]      x_s1;
	logic             last_s1;
	logic             out_valid_q;
	logic [11:0]      out_y_q;
	logic [10:0]      out_x_q;
	logic [31:0]      out_pix_q [8];
	logic             out_last_q;
	logic             advance;
	logic             do_load;
	logic             do_draw;
	logic             row_last;

	// sequencing control
	always_comb begin
		advance  = !out_valid_q || !out_stall;
		do_load  = head_valid && (head.kind == KIND_LOAD);
		do_draw  = head_valid && (head.kind == KIND_DRAW) && advance;
		row_last = (row_q == ROW_W'(GLYPH_ROWS - 1));
		pop      = do_load || (do_draw && row_last);
	end

	// font memory: one write port for loads, registered read for draws
	always_ff @(posedge clk) begin
		if (do_load) begin
			font_mem[{head.code, ROW_W'(head.font_row)}] <= head.font_bits;
		end
		if (do_draw) begin
			bits_s1 <= font_mem[{head.code, row_q}];
		end
	end

	// stage 1 payload alongside the memory read
	always_ff @(posedge clk) begin
		if (do_draw) begin
			fg_s1   <= head.fg_argb;
			bg_s1   <= head.bg_argb;
			y_s1    <= head.pix_y_base + 12'(row_q);
			x_s1    <= head.pix_x;
			last_s1 <= row_last;
		end
	end

	// output register payload: expand the row pattern into pixels
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_y_q    <= y_s1;
			out_x_q    <= x_s1;
			out_last_q <= last_s1;
			for (int i = 0; i < 8; i++) begin
				out_pix_q[i] <= bits_s1[7 - i] ? fg_s1 : bg_s1;
			end
		end
	end

	// row counter and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_draw) begin
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end
			if (advance) begin
				valid_s1    <= do_draw;
				out_valid_q <= valid_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_y   = out_y_q;
	assign pixel_x   = out_x_q;
	assign pixel_0   = out_pix_q[0];
	assign pixel_1   = out_pix_q[1];
	assign pixel_2   = out_pix_q[2];
	assign pixel_3   = out_pix_q[3];
	assign pixel_4   = out_pix_q[4];
	assign pixel_5   = out_pix_q[5];
	assign pixel_6   = out_pix_q[6];
	assign pixel_7   = out_pix_q[7];
	assign last      = out_last_q;

endmodule

// ===== rtl/text_cell_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_cell_glyph_renderer
// Text-mode character generator: font row loads and per-cell glyph drawing
// into rows of eight ARGB pixels.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | request   | in_valid / in_stall | cmd, char_code, colors, position,
//          |           |                     | font_row, font_bits
//  out     | result    | out_valid/out_stall | pixel_y, pixel_x, pixel_0..7, last
//
// A draw request yields GLYPH_ROWS results, one per cycle while out_stall is
// low, limited by the single font memory read port; the next request leaves
// the queue with the read of a cell's last row. A load writes one font row in
// the back end and yields no result. A draw passes the queue, stage 1 and the
// output register. Reset clears control only; the font memory is not
// cleared and must be loaded. out_stall freezes draws, not loads; the
// two-entry queue takes requests until it is full.
module text_cell_glyph_renderer import tccg_pkg::*; #(
	parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  char_code,
	input  logic [2:0]  fg_color,
	input  logic [2:0]  bg_color,
	input  logic        bold,
	input  logic        invert,
	input  logic [7:0]  cell_col,
	input  logic [7:0]  cell_row,
	input  logic [3:0]  font_row,
	input  logic [7:0]  font_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pixel_y,
	output logic [10:0] pixel_x,
	output logic [31:0] pixel_0,
	output logic [31:0] pixel_1,
	output logic [31:0] pixel_2,
	output logic [31:0] pixel_3,
	output logic [31:0] pixel_4,
	output logic [31:0] pixel_5,
	output logic [31:0] pixel_6,
	output logic [31:0] pixel_7,
	output logic        last
);

	logic   head_valid;
	entry_t head;
	logic   pop;

	// request intake and queue
	tccg_front #(
		.GLYPH_ROWS(GLYPH_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.fg_color   (fg_color),
		.bg_color   (bg_color),
		.bold       (bold),
		.invert     (invert),
		.cell_col   (cell_col),
		.cell_row   (cell_row),
		.font_row   (font_row),
		.font_bits  (font_bits),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// execution and pixel output
	tccg_back #(
		.GLYPH_ROWS(GLYPH_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_y    (pixel_y),
		.pixel_x    (pixel_x),
		.pixel_0    (pixel_0),
		.pixel_1    (pixel_1),
		.pixel_2    (pixel_2),
		.pixel_3    (pixel_3),
		.pixel_4    (pixel_4),
		.pixel_5    (pixel_5),
		.pixel_6    (pixel_6),
		.pixel_7    (pixel_7),
		.last       (last)
	);

endmodule

// ===== rtl/tccg_checker.sv =====
// ----------------------------------------------------------------------------
// tccg_checker
// Port-level checks on the renderer output stream, bound to the top level.
// ----------------------------------------------------------------------------
module tccg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] pixel_y,
	input logic [10:0] pixel_x,
	input logic [31:0] pixel_0,
	input logic        last
);

	logic out_take;

	assign out_take = out_valid && !out_stall;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its position, pixel_0 and last flag
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_y) && $stable(pixel_x)
			&& $stable(pixel_0) && $stable(last))
		else $error("result changed while stalled");

	// rows of a cell follow with no gap
	a_row_streams: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !last |=> out_valid)
		else $error("gap inside a cell");

	// next row of the same cell: same column, next pixel row
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !last |=> pixel_x == $past(pixel_x)
			&& pixel_y == 12'($past(pixel_y) + 12'd1))
		else $error("row position out of sequence");

endmodule

bind text_cell_glyph_renderer tccg_checker u_tccg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_y   (pixel_y),
	.pixel_x   (pixel_x),
	.pixel_0   (pixel_0),
	.last      (last)
);
